// ===== design/thermistor_beta_temperature_unit_macros.svh =====
// Assertion helpers for the thermistor temperature unit.
`ifndef THERMISTOR_BETA_TEMPERATURE_UNIT_MACROS_SVH
`define THERMISTOR_BETA_TEMPERATURE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// ante implies cons in the same cycle
`define TBT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// a rising edge of sig implies cons
`define TBT_ASSERT_ROSE(label, clk, rst_n, sig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $rose(sig) |-> (cons)) \
    else $error(msg);
`else
`define TBT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TBT_ASSERT_ROSE(label, clk, rst_n, sig, cons, msg)
`endif

`endif

// ===== design/tbt_pkg.sv =====
package tbt_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int LOG_DEPTH_BITS = 6;
  localparam int LOG_DEPTH      = 1 << LOG_DEPTH_BITS;
  localparam int TAB_W          = FRAC_BITS + 1;
  localparam int LOG_W          = FRAC_BITS + 7;
  localparam int LQ_W           = FRAC_BITS + 10;
  localparam int NUM_W          = 37;
  localparam int DEN_W          = FRAC_BITS + 28;
  localparam int QUO_W          = 17;
  localparam int REM_W          = DEN_W + QUO_W;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int KELVIN_OFFSET    = 27315;
  localparam int TEMP_MAX         = 32767;
  localparam logic [QUO_W-1:0] TCK_MAX = QUO_W'(TEMP_MAX + KELVIN_OFFSET);

  localparam int Q_AW      = 2;
  localparam int QDEPTH    = 1 << Q_AW;
  localparam int OUT_AW    = 5;
  localparam int OUT_DEPTH = 1 << OUT_AW;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULLUP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_OHMS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_CK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA         = 3'd5;

  typedef struct packed {
    logic [31:0] ratio_step;
    logic [19:0] pullup_ohms;
    logic [19:0] parallel_ohms;
    logic [19:0] nominal_ohms;
    logic [15:0] nominal_centikelvin;
    logic [13:0] beta_kelvin;
  } cfg_t;

  typedef struct packed {
    logic [31:0] q;
    logic        bad;
  } item_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               invalid;
  } result_t;

  typedef logic [TAB_W-1:0] log_tab_t [0:LOG_DEPTH];

  // log2(1 + i/depth), bit by bit through repeated squaring in Q30
  function automatic log_tab_t build_log_tab();
    log_tab_t         t;
    logic [63:0]      v;
    logic [TAB_W-1:0] acc;
    for (int i = 0; i <= LOG_DEPTH; i++) begin
      v   = ((64'(LOG_DEPTH) + 64'(i)) << 30) / LOG_DEPTH;
      acc = '0;
      if (v >= (64'd2 << 30)) begin
        acc = TAB_W'(1) << FRAC_BITS;
      end else begin
        for (int k = FRAC_BITS - 1; k >= 0; k--) begin
          v = (v * v) >> 30;
          if (v >= (64'd2 << 30)) begin
            v      = v >> 1;
            acc[k] = 1'b1;
          end
        end
      end
      t[i] = acc;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ===== design/tbt_front.sv =====
module tbt_front import tbt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_push,
  input  logic [15:0] in_ts_code,
  output logic        in_full,
  output logic        q_push,
  output item_t       q_item,
  input  logic        q_pop
);

  logic            acc;
  logic            v1_r, v2_r;
  logic [47:0]     prod1_r;
  item_t           item_r;
  logic [Q_AW:0]   held_r, held_nxt;

  // held counts items in flight here plus those sitting in the queue
  assign acc     = in_push && !in_full;
  assign in_full = (held_r == (Q_AW + 1)'(QDEPTH));
  assign q_push  = v2_r;
  assign q_item  = item_r;

  always_comb held_nxt = held_r + (Q_AW + 1)'(acc) - (Q_AW + 1)'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      held_r <= '0;
    end else begin
      v1_r   <= acc;
      v2_r   <= v1_r;
      held_r <= held_nxt;
    end
    prod1_r     <= 48'(in_ts_code) * 48'(cfg.ratio_step);
    item_r.q    <= prod1_r[31:0];
    item_r.bad  <= (prod1_r == '0) || (prod1_r[47:32] != '0) || (cfg.pullup_ohms == '0);
  end

endmodule

// ===== design/tbt_queue.sv =====
module tbt_queue import tbt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t           mem_r [0:QDEPTH-1];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   cnt_r;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + Q_AW'(push);
      rd_r  <= rd_r + Q_AW'(pop);
      cnt_r <= cnt_r + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
    end
  end

endmodule

// ===== design/tbt_log2.sv =====
module tbt_log2 import tbt_pkg::*; (
  input  logic             clk,
  input  logic [63:0]      x,
  output logic [LOG_W-1:0] y
);

  logic [63:0]               m_a, m_b, m1_r, m2_r;
  logic [5:0]                lz_a, lz_b, lz1_r, e2_r, e3_r;
  logic [31:0]               f, w;
  logic [LOG_DEPTH_BITS:0]   idx, idx_p1;
  logic [TAB_W-1:0]          lo, hi, diff, lo3_r;
  logic [TAB_W+31:0]         prod3_r;
  logic [LOG_W-1:0]          y_r;

  // normalize: coarse shifts
  always_comb begin
    m_a  = x;
    lz_a = '0;
    if (m_a[63:32] == '0) begin
      m_a  = m_a << 32;
      lz_a = lz_a + 6'd32;
    end
    if (m_a[63:48] == '0) begin
      m_a  = m_a << 16;
      lz_a = lz_a + 6'd16;
    end
    if (m_a[63:56] == '0) begin
      m_a  = m_a << 8;
      lz_a = lz_a + 6'd8;
    end
  end

  // normalize: fine shifts
  always_comb begin
    m_b  = m1_r;
    lz_b = lz1_r;
    if (m_b[63:60] == '0) begin
      m_b  = m_b << 4;
      lz_b = lz_b + 6'd4;
    end
    if (m_b[63:62] == '0) begin
      m_b  = m_b << 2;
      lz_b = lz_b + 6'd2;
    end
    if (!m_b[63]) begin
      m_b  = m_b << 1;
      lz_b = lz_b + 6'd1;
    end
  end

  // mantissa below the leading one picks table segment and weight
  always_comb begin
    f      = m2_r[62:31];
    idx    = {1'b0, f[31 -: LOG_DEPTH_BITS]};
    idx_p1 = idx + (LOG_DEPTH_BITS + 1)'(1);
    w      = {f[31-LOG_DEPTH_BITS:0], {LOG_DEPTH_BITS{1'b0}}};
    lo     = LOG_TAB[idx];
    hi     = LOG_TAB[idx_p1];
    diff   = (hi > lo) ? (hi - lo) : '0;
  end

  always_ff @(posedge clk) begin
    m1_r    <= m_a;
    lz1_r   <= lz_a;
    m2_r    <= m_b;
    e2_r    <= 6'd63 - lz_b;
    prod3_r <= (TAB_W + 32)'(diff) * (TAB_W + 32)'(w);
    lo3_r   <= lo;
    e3_r    <= e2_r;
    y_r     <= (LOG_W'(e3_r) << FRAC_BITS) + LOG_W'(lo3_r) + LOG_W'(prod3_r[TAB_W+31:32]);
  end

  assign y = y_r;

endmodule

// ===== design/tbt_back.sv =====
module tbt_back import tbt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    head_valid,
  input  item_t   head,
  output logic    head_pop,
  output logic    out_empty,
  input  logic    out_pop,
  output result_t out_data
);

  localparam int ST = 11 + QUO_W;

  typedef struct packed {
    logic v;
    logic bad;
    logic sat;
  } ctl_t;

  ctl_t ctl_r [1:ST];
  ctl_t ctl_nxt [1:ST];

  logic                    issue, pop_acc;
  logic [OUT_AW:0]         resv_r;

  // derived constants, follow config writes
  logic [29:0]             t0b_r;
  logic [NUM_W-1:0]        num_r;
  logic [DEN_W-2:0]        bk100_r;
  logic                    zero_t_r;

  logic [31:0]             q1_r, q2_r;
  logic [52:0]             a1_r;
  logic [51:0]             b1_r, d2_r;
  logic [LOG_W-1:0]        lg_q, lg_s, lg_p, lg_d, lg_n;
  logic signed [LQ_W-1:0]  lq7_r, lnq8_r, lnq_c;
  logic signed [DEN_W-1:0] den9_r;
  logic signed [16:0]      t0s;
  logic signed [LQ_W+16:0] tprod;
  logic [LQ_W-2:0]         mag, pmag;
  logic [LQ_W+30:0]        lnprod;
  logic [DEN_W-2:0]        du_c, du10_r;
  logic [REM_W-1:0]        nn_c, lim_c, rem10_r;
  logic                    sat_c;
  logic [REM_W-1:0]        rem_r [0:QUO_W-1];
  logic [QUO_W-1:0]        quo_r [0:QUO_W-1];
  logic [DEN_W-2:0]        du_r  [0:QUO_W-1];
  logic [QUO_W-1:0]        tck;
  result_t                 res_c, res_r;

  result_t                 mem_r [0:OUT_DEPTH-1];
  logic [OUT_AW-1:0]       wr_r, rd_r;
  logic [OUT_AW:0]         cnt_r;

  // a slot in the result buffer is reserved at issue, so the pipe never stalls
  assign pop_acc  = out_pop && !out_empty;
  assign issue    = head_valid && (resv_r != (OUT_AW + 1)'(OUT_DEPTH));
  assign head_pop = issue;

  always_ff @(posedge clk) begin
    t0b_r    <= 30'(cfg.nominal_centikelvin) * 30'(cfg.beta_kelvin);
    num_r    <= NUM_W'(t0b_r) * NUM_W'(100);
    bk100_r  <= (DEN_W - 1)'(21'(cfg.beta_kelvin) * 21'd100) << FRAC_BITS;
    zero_t_r <= (cfg.nominal_ohms == '0) || (num_r == '0);
  end

  // ---- resistance terms
  always_ff @(posedge clk) begin
    q1_r <= head.q;
    a1_r <= 53'(cfg.parallel_ohms) * (53'(33'h1_0000_0000) - 53'(head.q));
    b1_r <= 52'(cfg.pullup_ohms) * 52'(head.q);
    q2_r <= q1_r;
    d2_r <= 52'(a1_r - {1'b0, b1_r});
  end

  tbt_log2 u_log_q (.clk(clk), .x(64'(q2_r)),              .y(lg_q));
  tbt_log2 u_log_s (.clk(clk), .x(64'(cfg.pullup_ohms)),   .y(lg_s));
  tbt_log2 u_log_p (.clk(clk), .x(64'(cfg.parallel_ohms)), .y(lg_p));
  tbt_log2 u_log_d (.clk(clk), .x(64'(d2_r)),              .y(lg_d));
  tbt_log2 u_log_n (.clk(clk), .x(64'(cfg.nominal_ohms)),  .y(lg_n));

  // ---- log2 to ln, beta denominator
  always_comb begin
    mag    = lq7_r[LQ_W-1] ? (LQ_W - 1)'(-lq7_r) : (LQ_W - 1)'(lq7_r);
    lnprod = (LQ_W + 31)'(mag) * (LQ_W + 31)'(LN2_Q32);
    pmag   = lnprod[LQ_W+30:32];
    lnq_c  = lq7_r[LQ_W-1] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    t0s    = $signed({1'b0, cfg.nominal_centikelvin});
    tprod  = t0s * lnq8_r;
  end

  always_ff @(posedge clk) begin
    lq7_r  <= $signed(LQ_W'(lg_q)) + $signed(LQ_W'(lg_s)) + $signed(LQ_W'(lg_p))
              - $signed(LQ_W'(lg_d)) - $signed(LQ_W'(lg_n));
    lnq8_r <= lnq_c;
    den9_r <= $signed({1'b0, bk100_r}) + DEN_W'(tprod);
  end

  // ---- rounding offset and overflow check ahead of the divider
  always_comb begin
    du_c  = den9_r[DEN_W-2:0];
    nn_c  = (REM_W'(num_r) << FRAC_BITS) + REM_W'(du_c >> 1);
    lim_c = REM_W'(du_c) << QUO_W;
    sat_c = den9_r[DEN_W-1] || (den9_r == '0) || (nn_c >= lim_c);
  end

  always_ff @(posedge clk) begin
    rem10_r <= nn_c;
    du10_r  <= du_c;
  end

  // ---- restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [REM_W-1:0] rin, trial;
    logic [QUO_W-1:0] qin;
    logic [DEN_W-2:0] din;
    if (j == 0) begin : g_first
      assign rin = rem10_r;
      assign qin = '0;
      assign din = du10_r;
    end else begin : g_rest
      assign rin = rem_r[j-1];
      assign qin = quo_r[j-1];
      assign din = du_r[j-1];
    end
    assign trial = REM_W'(din) << (QUO_W - 1 - j);
    always_ff @(posedge clk) begin
      if (rin >= trial) begin
        rem_r[j] <= rin - trial;
        quo_r[j] <= qin | (QUO_W'(1) << (QUO_W - 1 - j));
      end else begin
        rem_r[j] <= rin;
        quo_r[j] <= qin;
      end
      du_r[j] <= din;
    end
  end

  // ---- final selection
  always_comb begin
    tck = quo_r[QUO_W-1];
    if (ctl_r[ST-1].bad) begin
      res_c.temp    = '0;
      res_c.invalid = 1'b1;
    end else if (zero_t_r) begin
      res_c.temp    = -16'sd27315;
      res_c.invalid = 1'b0;
    end else if (ctl_r[ST-1].sat || (tck > TCK_MAX)) begin
      res_c.temp    = 16'(TEMP_MAX);
      res_c.invalid = 1'b0;
    end else begin
      res_c.temp    = 16'(18'(tck) - 18'(KELVIN_OFFSET));
      res_c.invalid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_c;
  end

  // ---- control pipe
  always_comb begin
    ctl_nxt[1] = {issue, head.bad, 1'b0};
    for (int k = 2; k <= ST; k++) begin
      ctl_nxt[k] = ctl_r[k-1];
    end
    ctl_nxt[2].bad = ctl_r[1].bad || (a1_r <= {1'b0, b1_r});
    ctl_nxt[10].sat = sat_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ST; k++) begin
        ctl_r[k] <= '0;
      end
      resv_r <= '0;
    end else begin
      for (int k = 1; k <= ST; k++) begin
        ctl_r[k] <= ctl_nxt[k];
      end
      resv_r <= resv_r + (OUT_AW + 1)'(issue) - (OUT_AW + 1)'(pop_acc);
    end
  end

  // ---- result buffer
  assign out_empty = (cnt_r == '0);
  assign out_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (ctl_r[ST].v) begin
      mem_r[wr_r] <= res_r;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + OUT_AW'(ctl_r[ST].v);
      rd_r  <= rd_r + OUT_AW'(pop_acc);
      cnt_r <= cnt_r + (OUT_AW + 1)'(ctl_r[ST].v) - (OUT_AW + 1)'(pop_acc);
    end
  end

endmodule

// ===== design/thermistor_beta_temperature_unit.sv =====
// Channel   Direction  Handshake         Payload
// in_*      in         push / full       ts_code[15:0]
// out_*     out        pop / empty       temp_centi_c[15:0] signed, invalid
// cfg_*     in         we (no wait)      index[2:0], wdata[31:0]
//
// One transaction per cycle in steady state while a result buffer slot is free. A transaction
// passes the front stages, the 4-deep queue and 28 back stages (log2 units, a 17-stage
// restoring divider), then enters the 32-entry result buffer, at which point empty drops.
// Reset is synchronous; the log2 table is constant, so there is no clearing pass.
// full rises when front plus queue hold 4 transactions; the back issues only
// while a result buffer slot is free, so a stalled consumer backs up to full.
`include "thermistor_beta_temperature_unit_macros.svh"

module thermistor_beta_temperature_unit import tbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [15:0]          in_ts_code,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [15:0]   out_temp_centi_c,
  output logic                 out_invalid,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  cfg_t    cfg_r;
  logic    f_push, q_valid, q_pop;
  item_t   f_item, q_head;
  result_t res;

  // config registers; bits above each register's width are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio_step          <= 32'd4194304;
      cfg_r.pullup_ohms         <= 20'd5240;
      cfg_r.parallel_ohms       <= 20'd30100;
      cfg_r.nominal_ohms        <= 20'd10000;
      cfg_r.nominal_centikelvin <= 16'd29815;
      cfg_r.beta_kelvin         <= 14'd3435;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATIO_STEP:   cfg_r.ratio_step          <= cfg_wdata;
        CFG_PULLUP:       cfg_r.pullup_ohms         <= cfg_wdata[19:0];
        CFG_PARALLEL:     cfg_r.parallel_ohms       <= cfg_wdata[19:0];
        CFG_NOMINAL_OHMS: cfg_r.nominal_ohms        <= cfg_wdata[19:0];
        CFG_NOMINAL_CK:   cfg_r.nominal_centikelvin <= cfg_wdata[15:0];
        CFG_BETA:         cfg_r.beta_kelvin         <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  // front: ratio product and range classification
  tbt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_push    (in_push),
    .in_ts_code (in_ts_code),
    .in_full    (in_full),
    .q_push     (f_push),
    .q_item     (f_item),
    .q_pop      (q_pop)
  );

  tbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .din        (f_item),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back: resistance, logs, beta equation, division, result buffer
  tbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_valid),
    .head       (q_head),
    .head_pop   (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (res)
  );

  assign out_temp_centi_c = res.temp;
  assign out_invalid      = res.invalid;

  `TBT_ASSERT_IMPL(a_invalid_zero, clk, rst_n, !out_empty && out_invalid, out_temp_centi_c == 16'sd0, "invalid result with nonzero temperature")
  `TBT_ASSERT_IMPL(a_temp_floor, clk, rst_n, !out_empty && !out_invalid, out_temp_centi_c >= -16'sd27315, "temperature below absolute zero")
  `TBT_ASSERT_ROSE(a_full_after_push, clk, rst_n, in_full, $past(in_push) && !$past(in_full), "full rose without an accepted transaction")
  `TBT_ASSERT_ROSE(a_head_change, clk, rst_n, out_invalid, $past(out_empty) || $past(out_pop), "result head changed while held")

endmodule
